/* rtl/core/wed_pkg.sv */
`timescale 1ns / 1ps
// Package for the weighted Euclidean distance block: widths, limits and the
// command/status structs between controller and datapath. No dependencies.
package wed_pkg;

	// Vector length limit and fixed-point scaling
	localparam int MAX_ELEMENTS = 1024;
	localparam int FRAC_BITS    = 16;

	// Field widths
	localparam int IN_W   = 17;
	localparam int DIST_W = 22;
	localparam int ACC_W  = 43;

	// Arithmetic widths
	localparam int SQ_W   = 2 * IN_W;
	localparam int PROD_W = SQ_W + IN_W;
	localparam int TERM_W = PROD_W - FRAC_BITS;
	localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

	// Square root: one result bit per step
	localparam int ROOT_STEPS = DIST_W;
	localparam int RAD_W      = 2 * ROOT_STEPS;
	localparam int REM_W      = DIST_W + 3;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic do_sq;
		logic do_mul;
		logic do_acc;
		logic root_init;
		logic root_step;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;
		logic out_full;
	} dp_sts_t;

endpackage

/* rtl/core/wed_in_if.sv */
`timescale 1ns / 1ps
// Input request channel: one feature position per request.
// Depends on wed_pkg for field widths.
interface wed_in_if;
	logic                    valid;
	logic                    ready;
	logic [wed_pkg::IN_W-1:0] coord_a;
	logic [wed_pkg::IN_W-1:0] coord_b;
	logic [wed_pkg::IN_W-1:0] feature_weight;
	logic                    last_element;

	modport source (output valid, coord_a, coord_b, feature_weight, last_element,
		input ready);
	modport sink (input valid, coord_a, coord_b, feature_weight, last_element,
		output ready);
endinterface

/* rtl/core/wed_out_if.sv */
`timescale 1ns / 1ps
// Result request channel: distance and overflow mark per vector pair.
// Depends on wed_pkg for field widths.
interface wed_out_if;
	logic                      valid;
	logic                      ready;
	logic [wed_pkg::DIST_W-1:0] distance;
	logic                      overflowed;

	modport source (output valid, distance, overflowed, input ready);
	modport sink (input valid, distance, overflowed, output ready);
endinterface

/* rtl/core/wed_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences difference, multiply, accumulate and the
// bit-serial square root. Depends on wed_pkg.
module wed_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wed_pkg::dp_sts_t sts,
	output wed_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		DIFF,
		MULT,
		ACCUM,
		RINIT,
		ROOT,
		DONE
	} state_t;

	state_t                    state_q;
	logic [wed_pkg::STEP_W-1:0] step_q;

	assign in_ready = (state_q == IDLE);

	// Commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE:    cmd.load_in   = in_valid;
			DIFF:    cmd.do_sq     = 1'b1;
			MULT:    cmd.do_mul    = 1'b1;
			ACCUM:   cmd.do_acc    = 1'b1;
			RINIT:   cmd.root_init = 1'b1;
			ROOT:    cmd.root_step = 1'b1;
			DONE:    cmd.out_load  = !sts.out_full;
			default: cmd = '0;
		endcase
	end

	// State and root step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) state_q <= DIFF;
				end
				DIFF:  state_q <= MULT;
				MULT:  state_q <= ACCUM;
				ACCUM: state_q <= sts.last ? RINIT : IDLE;
				RINIT: begin
					step_q  <= '0;
					state_q <= ROOT;
				end
				ROOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == wed_pkg::STEP_W'(wed_pkg::ROOT_STEPS - 1)) state_q <= DONE;
				end
				DONE: begin
					if (!sts.out_full) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/wed_datapath.sv */
`timescale 1ns / 1ps
// Datapath: input registers, two multiplier stages, saturating accumulator,
// restoring square root and the result register. Depends on wed_pkg.
module wed_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wed_pkg::dp_cmd_t            cmd,
	output wed_pkg::dp_sts_t            sts,
	input  logic [wed_pkg::IN_W-1:0]    coord_a,
	input  logic [wed_pkg::IN_W-1:0]    coord_b,
	input  logic [wed_pkg::IN_W-1:0]    feature_weight,
	input  logic                        last_element,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wed_pkg::DIST_W-1:0]  distance,
	output logic                        overflowed
);

	logic [wed_pkg::IN_W-1:0]   a_q, b_q, w_q;
	logic                       last_q;
	logic [wed_pkg::IN_W-1:0]   diff;
	logic [wed_pkg::SQ_W-1:0]   dsq_q;
	logic [wed_pkg::PROD_W-1:0] prod;
	logic [wed_pkg::TERM_W-1:0] term_q;
	logic [wed_pkg::ACC_W:0]    sum;
	logic [wed_pkg::ACC_W-1:0]  acc_q;
	logic [wed_pkg::CNT_W-1:0]  cnt_q;
	logic                       sat_q;
	logic                       count_full;
	logic [wed_pkg::RAD_W-1:0]  rad_q;
	logic [wed_pkg::REM_W-1:0]  rem_q, rem_sh, trial;
	logic [wed_pkg::DIST_W-1:0] root_q;
	logic                       fits;
	logic [wed_pkg::DIST_W-1:0] dist_q;
	logic                       ovf_q;
	logic                       out_valid_q;

	// Arithmetic
	assign diff       = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
	assign prod       = wed_pkg::PROD_W'(dsq_q) * wed_pkg::PROD_W'(w_q);
	assign sum        = (wed_pkg::ACC_W + 1)'(acc_q) + (wed_pkg::ACC_W + 1)'(term_q);
	assign count_full = (cnt_q >= wed_pkg::CNT_W'(wed_pkg::MAX_ELEMENTS));

	// One root bit per step: bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q[wed_pkg::REM_W-3:0], rad_q[wed_pkg::RAD_W-1 -: 2]};
	assign trial  = wed_pkg::REM_W'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q    <= coord_a;
			b_q    <= coord_b;
			w_q    <= feature_weight;
			last_q <= last_element;
		end
		if (cmd.do_sq)  dsq_q  <= wed_pkg::SQ_W'(diff) * wed_pkg::SQ_W'(diff);
		if (cmd.do_mul) term_q <= prod[wed_pkg::PROD_W-1:wed_pkg::FRAC_BITS];
		if (cmd.root_init) begin
			rad_q  <= wed_pkg::RAD_W'(acc_q);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[wed_pkg::DIST_W-2:0], fits};
		end
		if (cmd.out_load) begin
			dist_q <= root_q;
			ovf_q  <= sat_q;
		end
	end

	// Per-vector state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				acc_q       <= '0;
				cnt_q       <= '0;
				sat_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (out_valid_q && out_ready) out_valid_q <= 1'b0;
				if (cmd.do_acc) begin
					if (count_full) begin
						sat_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (sum[wed_pkg::ACC_W]) begin
							acc_q <= wed_pkg::ACC_MAX;
							sat_q <= 1'b1;
						end else begin
							acc_q <= sum[wed_pkg::ACC_W-1:0];
						end
					end
				end
			end
		end
	end

	assign sts.last     = last_q;
	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign distance     = dist_q;
	assign overflowed   = ovf_q;

endmodule

/* rtl/core/weighted_euclidean_distance.sv */
`timescale 1ns / 1ps
// Weighted Euclidean distance, one feature position per input request.
// A request that is not last goes through load, square, weight and add before the next is taken.
// A last request then loads the radicand, runs 22 root steps of one bit each and registers
// the result; the next request is taken only after that, and later while an earlier result
// still waits for its reader.
// Asynchronous active-low reset clears accumulator, element count, flag and result valid.
module weighted_euclidean_distance (
	input logic clk,
	input logic arst_n,
	wed_in_if.sink    in_ch,
	wed_out_if.source out_ch
);

	wed_pkg::dp_cmd_t cmd;
	wed_pkg::dp_sts_t sts;

	wed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wed_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.coord_a        (in_ch.coord_a),
		.coord_b        (in_ch.coord_b),
		.feature_weight (in_ch.feature_weight),
		.last_element   (in_ch.last_element),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.distance       (out_ch.distance),
		.overflowed     (out_ch.overflowed)
	);

endmodule

/* rtl/core/wed_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the weighted Euclidean distance block, bound to the top.
// Depends on wed_pkg and the top level's channel interfaces.
module wed_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [wed_pkg::DIST_W-1:0] distance,
	input logic                       overflowed
);

	// Result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance) && $stable(overflowed))
		else $error("result changed while stalled");

	// One request in flight: ready drops after each accepted request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in flight");

	// A result only appears at the end of a vector's root, never from idle
	a_result_from_root: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a finished root");

endmodule

bind weighted_euclidean_distance wed_checker u_wed_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.distance   (out_ch.distance),
	.overflowed (out_ch.overflowed)
);

/* test/tb_weighted_euclidean_distance.sv */
`timescale 1ns / 1ps
// Self-checking testbench for weighted_euclidean_distance: directed, then random vectors with
// random stalls on both channels, long at the receiver. Needs wed_pkg, wed_in_if, wed_out_if.
module tb_weighted_euclidean_distance;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [wed_pkg::IN_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [wed_pkg::IN_W-1:0] TOP_IN  = {wed_pkg::IN_W{1'b1}};

	typedef struct packed {
		logic [wed_pkg::IN_W-1:0] a;
		logic [wed_pkg::IN_W-1:0] b;
		logic [wed_pkg::IN_W-1:0] w;
		logic                     last;
	} feature_t;

	typedef struct packed {
		logic [wed_pkg::DIST_W-1:0] distance;
		logic                       overflowed;
	} distance_t;

	logic clk;
	logic arst_n;

	wed_in_if  in_ch ();
	wed_out_if out_ch ();

	weighted_euclidean_distance u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Requests waiting to be sent, distances waiting to arrive
	feature_t  feature_queue[$];
	distance_t distance_queue[$];

	// Predicted accumulator state for the vector pair in flight
	logic [wed_pkg::ACC_W-1:0] acc_sum = '0;
	int                        elem_cnt = 0;
	logic                      sat_mark = 1'b0;

	feature_t send_item;
	int       send_gap;
	int       recv_wait;
	int       hold_cnt;
	bit       hold_req = 1'b0;
	bit       no_idle = 1'b0;
	int       cycle_cnt = 0;
	int       error_cnt = 0;
	int       requests_sent = 0;
	int       vectors_queued = 0;
	int       distances_checked = 0;
	int       overflow_results = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Truncated square root, one result bit at a time from the top
	function automatic logic [wed_pkg::DIST_W-1:0] floor_root(input logic [63:0] radicand);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = wed_pkg::DIST_W - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= radicand) root = trial;
		end
		return root[wed_pkg::DIST_W-1:0];
	endfunction

	// Fold one accepted feature into the predicted sum; a last one yields a distance
	task automatic fold_feature(input feature_t f);
		logic [wed_pkg::IN_W-1:0] diff;
		logic [63:0]              term;
		logic [63:0]              total;
		distance_t                res;
		if (elem_cnt >= wed_pkg::MAX_ELEMENTS) begin
			// vector too long: element dropped, flag raised
			sat_mark = 1'b1;
		end else begin
			diff = (f.a >= f.b) ? f.a - f.b : f.b - f.a;
			term = (64'(diff) * 64'(diff) * 64'(f.w)) >> wed_pkg::FRAC_BITS;
			total = 64'(acc_sum) + term;
			if (total > 64'(wed_pkg::ACC_MAX)) begin
				total = 64'(wed_pkg::ACC_MAX);
				sat_mark = 1'b1;
			end
			acc_sum = total[wed_pkg::ACC_W-1:0];
			elem_cnt++;
		end
		if (f.last) begin
			res.distance = floor_root(64'(acc_sum));
			res.overflowed = sat_mark;
			distance_queue.push_back(res);
			if (sat_mark) overflow_results++;
			acc_sum = '0;
			elem_cnt = 0;
			sat_mark = 1'b0;
		end
	endtask

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	// Feature values: mostly in range, some extremes, some above 1.0
	function automatic logic [wed_pkg::IN_W-1:0] draw_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_Q16;
			2: return TOP_IN;
			3, 4: return wed_pkg::IN_W'($urandom_range(0, 131071));
			default: return wed_pkg::IN_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic queue_feature(input logic [wed_pkg::IN_W-1:0] a,
		input logic [wed_pkg::IN_W-1:0] b, input logic [wed_pkg::IN_W-1:0] w,
		input logic last);
		feature_t f;
		f.a = a;
		f.b = b;
		f.w = w;
		f.last = last;
		feature_queue.push_back(f);
		if (last) vectors_queued++;
	endtask

	// A vector of n identical features, the last one marked
	task automatic queue_run(input int n, input logic [wed_pkg::IN_W-1:0] a,
		input logic [wed_pkg::IN_W-1:0] b, input logic [wed_pkg::IN_W-1:0] w);
		for (int i = 0; i < n; i++) queue_feature(a, b, w, i == n - 1);
	endtask

	// Random vectors until about n features have been queued
	task automatic queue_random(input int n);
		int count;
		int len;
		count = 0;
		while (count < n) begin
			case ($urandom_range(0, 19))
				0: len = $urandom_range(17, 64);
				1, 2, 3, 4, 5: len = $urandom_range(5, 16);
				default: len = $urandom_range(1, 4);
			endcase
			for (int i = 0; i < len; i++)
				queue_feature(draw_value(), draw_value(), draw_value(), i == len - 1);
			count += len;
		end
	endtask

	// Wait until every queued request is sent and every distance has come back
	task automatic drain();
		@(negedge clk);
		while (feature_queue.size() != 0 || in_ch.valid || distance_queue.size() != 0)
			@(negedge clk);
	endtask

	// Driver: one request at a time, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.coord_a <= '0;
			in_ch.coord_b <= '0;
			in_ch.feature_weight <= '0;
			in_ch.last_element <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				fold_feature(send_item);
				requests_sent++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (feature_queue.size() != 0) begin
					send_item = feature_queue.pop_front();
					in_ch.coord_a <= send_item.a;
					in_ch.coord_b <= send_item.b;
					in_ch.feature_weight <= send_item.w;
					in_ch.last_element <= send_item.last;
					in_ch.valid <= 1'b1;
					send_gap = draw_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req) begin
			hold_cnt <= HOLD_CYCLES;
		end
	end

	// Monitor: check each distance against the oldest prediction, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (distance_queue.size() == 0) begin
					if (error_cnt < 10)
						$display("unexpected distance %0d overflowed %0b", out_ch.distance,
							out_ch.overflowed);
					error_cnt++;
				end else begin
					distances_checked++;
					if (out_ch.distance !== distance_queue[0].distance ||
						out_ch.overflowed !== distance_queue[0].overflowed) begin
						if (error_cnt < 10)
							$display("mismatch: expected distance %0d overflowed %0b, got %0d %0b",
								distance_queue[0].distance, distance_queue[0].overflowed,
								out_ch.distance, out_ch.overflowed);
						error_cnt++;
					end
					void'(distance_queue.pop_front());
				end
				recv_wait = draw_gap();
			end
			if (hold_cnt != 0) begin
				out_ch.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single-element extremes, both difference signs, equal coordinates
		queue_feature('0, '0, '0, 1'b1);
		queue_feature(ONE_Q16, '0, ONE_Q16, 1'b1);
		queue_feature('0, ONE_Q16, ONE_Q16, 1'b1);
		queue_feature(TOP_IN, '0, TOP_IN, 1'b1);
		queue_feature('0, TOP_IN, TOP_IN, 1'b1);
		queue_feature(17'd40000, 17'd40000, TOP_IN, 1'b1);
		queue_feature(17'd12345, 17'd54321, '0, 1'b1);
		// short vector with non-last elements
		queue_feature(17'd1000, 17'd3000, ONE_Q16, 1'b0);
		queue_feature(17'd65000, 17'd100, 17'd32768, 1'b0);
		queue_feature(17'd7, 17'd70000, 17'd1, 1'b1);
		// accumulator saturation
		queue_run(270, TOP_IN, '0, TOP_IN);
		drain();

		// Random vectors with random idling on both sides
		queue_random(150);
		drain();

		// Back-to-back stretch with no idling
		no_idle = 1'b1;
		queue_random(100);
		drain();
		no_idle = 1'b0;

		// Receiver holds off while the sender keeps offering requests
		queue_random(150);
		hold_req = 1'b1;
		while (hold_cnt == 0) @(negedge clk);
		hold_req = 1'b0;
		drain();

		repeat (40) @(negedge clk);
		$display("Sent %0d feature requests in %0d vector pairs, directed and random.",
			requests_sent, vectors_queued);
		$display("Checked %0d distances, %0d of them with the overflow mark.",
			distances_checked, overflow_results);
		if (error_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
